/* hdl/sfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser package
// Shared constants, character codes and the result payload type.
// ----------------------------------------------------------------------------
package sfp_pkg;

  localparam int ID_CHARS     = 5;
  localparam int MSG_DIGITS   = 2;
  localparam int PARAM_DIGITS = 8;

  localparam int SENSOR_W = 3;
  localparam int MSG_W    = 7;
  localparam int PARAM_W  = 27;
  localparam int BYTE_W   = 8;

  localparam int ID_CNT_W    = $clog2(ID_CHARS + 1);
  localparam int ID_IDX_W    = (ID_CHARS > 1) ? $clog2(ID_CHARS) : 1;
  localparam int MSG_CNT_W   = $clog2(MSG_DIGITS + 1);
  localparam int PARAM_CNT_W = $clog2(PARAM_DIGITS + 1);

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam int NAME_LEN  = 5;
  localparam int NUM_NAMES = 5;
  localparam logic [NAME_LEN*8-1:0] SENSOR_NAMES [NUM_NAMES] = '{
    "CNTRL", "ACST1", "PRS01", "HZ21W", "DS18B"
  };

  localparam logic [SENSOR_W-1:0] SENSOR_NONE = 3'd0;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_code;
    logic [MSG_W-1:0]    message_number;
    logic [PARAM_W-1:0]  param_value;
    logic [BYTE_W-1:0]   received_sum;
    logic                sum_matches;
  } result_t;

  typedef struct packed {
    logic head_valid;
    logic skid_valid;
  } buf_status_t;

endpackage

/* hdl/sfp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser channels
// Valid/ready channels for received bytes and parsed frame results.
// ----------------------------------------------------------------------------
interface sfp_byte_if import sfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_result_if import sfp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SENSOR_W-1:0] sensor_code;
  logic [MSG_W-1:0]    message_number;
  logic [PARAM_W-1:0]  param_value;
  logic [BYTE_W-1:0]   received_sum;
  logic                sum_matches;

  modport source (
    output valid, output sensor_code, output message_number, output param_value,
    output received_sum, output sum_matches, input ready
  );
  modport sink (
    input valid, input sensor_code, input message_number, input param_value,
    input received_sum, input sum_matches, output ready
  );
endinterface

/* hdl/sfp_parse_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser core
// Frame state registers and the per-beat next-state and result logic.
// ----------------------------------------------------------------------------
module sfp_parse_core import sfp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              beat,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              push,
  output result_t           result
);

  typedef enum logic [2:0] {
    PH_IDLE, PH_ID, PH_MSG, PH_PARAM, PH_STAR, PH_SUM
  } phase_t;

  phase_t                   parse_phase, parse_phase_next;
  logic [7:0]               id_chars [ID_CHARS];
  logic [7:0]               id_chars_next [ID_CHARS];
  logic [ID_CNT_W-1:0]      id_count, id_count_next;
  logic [MSG_CNT_W-1:0]     msg_digit_count, msg_digit_count_next;
  logic [PARAM_CNT_W-1:0]   param_digit_count, param_digit_count_next;
  logic                     sum_char_count, sum_char_count_next;
  logic [7:0]               first_hex_char, first_hex_char_next;
  logic [7:0]               running_xor, running_xor_next;
  logic [SENSOR_W-1:0]      cur_sensor, cur_sensor_next;
  logic [MSG_W-1:0]         cur_message, cur_message_next;
  logic [PARAM_W-1:0]       cur_param, cur_param_next;

  logic [MSG_W-1:0]         msg_acc;
  logic [PARAM_W-1:0]       param_acc;
  logic [SENSOR_W-1:0]      id_match;
  logic [7:0]               sum_value;

  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= "0" && c <= "9") v = {1'b0, 4'(c - "0")};
    else if (c >= "a" && c <= "f") v = {1'b0, 4'(c - "a" + 8'd10)};
    else if (c >= "A" && c <= "F") v = {1'b0, 4'(c - "A" + 8'd10)};
    return v;
  endfunction

  function automatic logic [7:0] parse_two_hex(input logic [7:0] a, input logic [7:0] b);
    logic [4:0] va;
    logic [4:0] vb;
    logic [7:0] r;
    va = hex_value(a);
    vb = hex_value(b);
    r  = 8'd0;
    if (!va[4]) begin
      r = vb[4] ? {4'd0, va[3:0]} : {va[3:0], vb[3:0]};
    end else if (!vb[4]) begin
      if (a == CH_SPACE || (a >= 8'd9 && a <= 8'd13) || a == CH_PLUS) begin
        r = {4'd0, vb[3:0]};
      end else if (a == CH_MINUS) begin
        r = 8'd0 - {4'd0, vb[3:0]};
      end
    end
    return r;
  endfunction

  // Multiply-by-ten plus digit offset, wrapping at the field width.
  assign msg_acc = {cur_message[MSG_W-4:0], 3'b000} + {cur_message[MSG_W-2:0], 1'b0}
                 + MSG_W'(rx_byte) - MSG_W'(CH_ZERO);
  assign param_acc = {cur_param[PARAM_W-4:0], 3'b000} + {cur_param[PARAM_W-2:0], 1'b0}
                   + PARAM_W'(rx_byte) - PARAM_W'(CH_ZERO);

  assign sum_value = parse_two_hex(first_hex_char, rx_byte);

  // Match against the id array as it stands after this beat's write.
  always_comb begin
    logic same;
    id_match = SENSOR_NONE;
    for (int n = NUM_NAMES - 1; n >= 0; n--) begin
      same = (ID_CHARS == NAME_LEN);
      for (int k = 0; k < ID_CHARS; k++) begin
        if (k < NAME_LEN) begin
          if (id_chars_next[k] != SENSOR_NAMES[n][(NAME_LEN-1-k)*8 +: 8]) same = 1'b0;
        end
      end
      if (same) id_match = SENSOR_W'(n + 1);
    end
  end

  always_comb begin
    parse_phase_next       = parse_phase;
    id_chars_next          = id_chars;
    id_count_next          = id_count;
    msg_digit_count_next   = msg_digit_count;
    param_digit_count_next = param_digit_count;
    sum_char_count_next    = sum_char_count;
    first_hex_char_next    = first_hex_char;
    running_xor_next       = running_xor;
    cur_sensor_next        = cur_sensor;
    cur_message_next       = cur_message;
    cur_param_next         = cur_param;
    push                   = 1'b0;

    if (rx_byte == CH_DOLLAR) begin
      running_xor_next       = rx_byte;
      id_count_next          = '0;
      msg_digit_count_next   = '0;
      param_digit_count_next = '0;
      sum_char_count_next    = 1'b0;
      cur_sensor_next        = SENSOR_NONE;
      cur_message_next       = '0;
      cur_param_next         = '0;
      parse_phase_next       = PH_ID;
    end else begin
      case (parse_phase)
        PH_ID: begin
          running_xor_next = running_xor ^ rx_byte;
          if (rx_byte == CH_COMMA) begin
            parse_phase_next = PH_MSG;
          end else if (id_count < ID_CNT_W'(ID_CHARS)) begin
            id_chars_next[id_count[ID_IDX_W-1:0]] = rx_byte;
            id_count_next = id_count + 1'b1;
            if (id_count_next == ID_CNT_W'(ID_CHARS)) begin
              cur_sensor_next = id_match;
              if (id_match == SENSOR_NONE) parse_phase_next = PH_IDLE;
            end
          end
        end
        PH_MSG: begin
          running_xor_next = running_xor ^ rx_byte;
          if (rx_byte == CH_COMMA) begin
            parse_phase_next = PH_PARAM;
          end else if (msg_digit_count < MSG_CNT_W'(MSG_DIGITS)) begin
            cur_message_next     = msg_acc;
            msg_digit_count_next = msg_digit_count + 1'b1;
          end
        end
        PH_PARAM: begin
          running_xor_next = running_xor ^ rx_byte;
          if (rx_byte == CH_COMMA) begin
            parse_phase_next = PH_STAR;
          end else if (param_digit_count < PARAM_CNT_W'(PARAM_DIGITS)) begin
            cur_param_next         = param_acc;
            param_digit_count_next = param_digit_count + 1'b1;
          end
        end
        PH_STAR: begin
          running_xor_next = running_xor ^ rx_byte;
          if (rx_byte == CH_COMMA) parse_phase_next = PH_SUM;
        end
        PH_SUM: begin
          if (!sum_char_count) begin
            first_hex_char_next = rx_byte;
            sum_char_count_next = 1'b1;
          end else begin
            sum_char_count_next = 1'b0;
            parse_phase_next    = PH_IDLE;
            push                = beat;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign result.sensor_code    = cur_sensor;
  assign result.message_number = cur_message;
  assign result.param_value    = cur_param;
  assign result.received_sum   = sum_value;
  assign result.sum_matches    = (sum_value == running_xor);

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase       <= PH_IDLE;
      id_count          <= '0;
      msg_digit_count   <= '0;
      param_digit_count <= '0;
      sum_char_count    <= 1'b0;
      running_xor       <= '0;
      cur_sensor        <= SENSOR_NONE;
      cur_message       <= '0;
      cur_param         <= '0;
    end else if (beat) begin
      parse_phase       <= parse_phase_next;
      id_count          <= id_count_next;
      msg_digit_count   <= msg_digit_count_next;
      param_digit_count <= param_digit_count_next;
      sum_char_count    <= sum_char_count_next;
      running_xor       <= running_xor_next;
      cur_sensor        <= cur_sensor_next;
      cur_message       <= cur_message_next;
      cur_param         <= cur_param_next;
    end
  end

  // Id characters and the first checksum character hold no reset value.
  always_ff @(posedge clk) begin
    if (beat) begin
      id_chars       <= id_chars_next;
      first_hex_char <= first_hex_char_next;
    end
  end

endmodule

/* hdl/sfp_out_buf.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser output buffer
// Result register with a skid stage so input beats continue under stall.
// ----------------------------------------------------------------------------
module sfp_out_buf import sfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  result_t     push_data,
  input  logic        pop_ready,
  output logic        head_valid,
  output result_t     head_data,
  output logic        space,
  output buf_status_t status
);

  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop   = head_valid && pop_ready;
  assign space = !skid_valid;

  assign status.head_valid = head_valid;
  assign status.skid_valid = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        head_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      // Park the beat in the skid stage while the head waits.
      if (head_valid) skid_valid <= 1'b1;
      else head_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      if (head_valid) skid_data <= push_data;
      else head_data <= push_data;
    end
  end

endmodule

/* hdl/sensor_frame_parser_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser
// Parses $ID,MM,PPPPPPPP,*,CC frames one byte per beat with XOR check.
// ----------------------------------------------------------------------------
// Throughput: one byte beat per cycle, sustained while results are taken.
// The last checksum beat registers the result in head, or skid while head stalls.
// A two-entry result buffer (head plus skid) drops rx ready only while both wait.
// Reset (rst, synchronous) returns the parser to idle and empties the buffer.
module sensor_frame_parser_core import sfp_pkg::*; (
  input logic         clk,
  input logic         rst,
  sfp_byte_if.sink    rx,
  sfp_result_if.source res
);

  logic        beat;
  logic        push;
  logic        space;
  result_t     core_result;
  result_t     head_data;
  buf_status_t status;

  assign rx.ready = space;
  assign beat     = rx.valid && space;

  sfp_parse_core u_core (
    .clk     (clk),
    .rst     (rst),
    .beat    (beat),
    .rx_byte (rx.rx_byte),
    .push    (push),
    .result  (core_result)
  );

  sfp_out_buf u_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (core_result),
    .pop_ready  (res.ready),
    .head_valid (res.valid),
    .head_data  (head_data),
    .space      (space),
    .status     (status)
  );

  assign res.sensor_code    = head_data.sensor_code;
  assign res.message_number = head_data.message_number;
  assign res.param_value    = head_data.param_value;
  assign res.received_sum   = head_data.received_sum;
  assign res.sum_matches    = head_data.sum_matches;

  a_reset_empty: assert property (@(posedge clk) rst |=> !res.valid)
    else $error("result valid after reset");

  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    status.skid_valid |-> status.head_valid)
    else $error("skid stage full with empty head");

  a_push_on_beat: assert property (@(posedge clk) disable iff (rst)
    push |-> beat)
    else $error("result pushed without an accepted beat");

  a_skid_no_beat: assert property (@(posedge clk) disable iff (rst)
    status.skid_valid |-> !rx.ready)
    else $error("beat accepted with buffer full");

endmodule

/* tb/sensor_frame_parser_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame parser testbench
// Streams $ID,MM,PPPPPPPP,*,CC frames, noise and cut-off frames into the
// parser with random gaps and result stalls. Each accepted byte beat goes
// through a local frame decoder, and every result beat is checked against
// the oldest decoded frame.
// ----------------------------------------------------------------------------
module sensor_frame_parser_core_tb;
  import sfp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int STREAM_BYTES = 1700;
  localparam int DRAIN_CYCLES = 20;
  localparam int ID_LEN       = 5;

  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam logic [ID_LEN*8-1:0] KNOWN_IDS [5] = '{
    "CNTRL", "ACST1", "PRS01", "HZ21W", "DS18B"
  };

  typedef enum logic [2:0] {
    P_IDLE, P_ID, P_MSG, P_PARAM, P_STAR, P_SUM
  } parse_phase_t;

  logic clk;
  logic rst;

  sfp_byte_if   rx_if ();
  sfp_result_if res_if ();

  sensor_frame_parser_core dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if)
  );

  // Stimulus and scoreboard storage
  logic [7:0] byte_q [$];
  result_t    frame_q [$];
  logic [7:0] gen_xor;
  int         frame_bytes = 0;
  int         byte_total  = 0;
  int         bytes_taken = 0;
  int         fail_cnt    = 0;
  int         cycle_cnt   = 0;

  // Decoder state
  parse_phase_t         phase = P_IDLE;
  logic [ID_LEN*8-1:0]  id_word = '0;
  int                   id_seen = 0;
  int                   msg_seen = 0;
  int                   prm_seen = 0;
  bit                   have_first = 1'b0;
  logic [7:0]           first_char = '0;
  logic [7:0]           frame_xor = '0;
  logic [SENSOR_W-1:0]  cur_code = SENSOR_NONE;
  int unsigned          cur_msg = 0;
  int unsigned          cur_prm = 0;

  // Handshake pacing
  int  send_gap  = 0;
  int  take_stall = 0;
  bit  send_calm = 1'b0;
  bit  take_calm = 1'b0;

  function automatic int hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  // Decode one accepted byte; return 1 when it completes a frame.
  function automatic bit take_byte(input logic [7:0] c, output result_t frame);
    int         va;
    int         vb;
    logic [7:0] chk;
    frame = '0;
    if (c == CH_DOLLAR) begin
      frame_xor  = c;
      id_seen    = 0;
      msg_seen   = 0;
      prm_seen   = 0;
      have_first = 1'b0;
      cur_code   = SENSOR_NONE;
      cur_msg    = 0;
      cur_prm    = 0;
      phase      = P_ID;
      return 1'b0;
    end
    case (phase)
      P_ID: begin
        frame_xor ^= c;
        if (c == CH_COMMA) begin
          phase = P_MSG;
        end else if (id_seen < ID_LEN) begin
          id_word = {id_word[ID_LEN*8-9:0], c};
          id_seen++;
          if (id_seen == ID_LEN) begin
            for (int n = 0; n < 5; n++)
              if (cur_code == SENSOR_NONE && id_word == KNOWN_IDS[n])
                cur_code = SENSOR_W'(n + 1);
            if (cur_code == SENSOR_NONE) phase = P_IDLE;
          end
        end
      end
      P_MSG: begin
        frame_xor ^= c;
        if (c == CH_COMMA) begin
          phase = P_PARAM;
        end else if (msg_seen < MSG_DIGITS) begin
          cur_msg = (cur_msg * 10 + c - 48) & ((1 << MSG_W) - 1);
          msg_seen++;
        end
      end
      P_PARAM: begin
        frame_xor ^= c;
        if (c == CH_COMMA) begin
          phase = P_STAR;
        end else if (prm_seen < PARAM_DIGITS) begin
          cur_prm = (cur_prm * 10 + c - 48) & ((1 << PARAM_W) - 1);
          prm_seen++;
        end
      end
      P_STAR: begin
        frame_xor ^= c;
        if (c == CH_COMMA) phase = P_SUM;
      end
      P_SUM: begin
        if (!have_first) begin
          first_char = c;
          have_first = 1'b1;
          return 1'b0;
        end
        // Checksum text follows strtol base-16 rules
        va = hex_val(first_char);
        vb = hex_val(c);
        if (va >= 0)
          chk = (vb >= 0) ? 8'(va * 16 + vb) : 8'(va);
        else if (vb < 0)
          chk = 8'd0;
        else if (first_char == CH_SPACE || first_char == CH_PLUS ||
                 (first_char >= CH_TAB && first_char <= CH_CR))
          chk = 8'(vb);
        else if (first_char == CH_MINUS)
          chk = 8'(256 - vb);
        else
          chk = 8'd0;
        have_first           = 1'b0;
        phase                = P_IDLE;
        frame.sensor_code    = cur_code;
        frame.message_number = MSG_W'(cur_msg);
        frame.param_value    = PARAM_W'(cur_prm);
        frame.received_sum   = chk;
        frame.sum_matches    = (chk == frame_xor);
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // ---- frame generation ----

  function automatic void put(logic [7:0] b);
    byte_q.push_back(b);
    gen_xor ^= b;
    frame_bytes++;
  endfunction

  // Checksum characters are outside the XOR.
  function automatic void put_raw(logic [7:0] b);
    byte_q.push_back(b);
    frame_bytes++;
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void open_frame();
    gen_xor = '0;
    put(CH_DOLLAR);
  endfunction

  function automatic void put_id(int n);
    for (int i = ID_LEN - 1; i >= 0; i--) put(KNOWN_IDS[n][i*8 +: 8]);
  endfunction

  function automatic logic [7:0] hex_char(int v);
    if (v < 10) return CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
  endfunction

  function automatic void close_good();
    put_raw(hex_char(gen_xor[7:4]));
    put_raw(hex_char(gen_xor[3:0]));
  endfunction

  function automatic logic [7:0] field_char(bit digit);
    logic [7:0] c;
    if (digit) return CH_ZERO + 8'($urandom_range(0, 9));
    do c = 8'($urandom_range(0, 255)); while (c == CH_DOLLAR || c == CH_COMMA);
    return c;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    do c = field_char(1'b0); while (hex_val(c) >= 0);
    return c;
  endfunction

  // Build one frame; cut below 6 stops it early after that many parts.
  function automatic void gen_frame(int cut);
    int         r;
    int         n;
    logic [7:0] bad;
    open_frame();
    r = $urandom_range(0, 99);
    if (r < 75) begin
      put_id($urandom_range(0, 4));
    end else if (r < 83) begin
      put_id($urandom_range(0, 4));
      repeat ($urandom_range(1, 3)) put(field_char(1'b0));
    end else if (r < 91) begin
      repeat ($urandom_range(0, 4)) put(field_char(1'b0));
    end else begin
      repeat (ID_LEN) put(field_char($urandom_range(0, 1)));
    end
    if (cut == 1) return;
    put(CH_COMMA);
    repeat ($urandom_range(0, 3)) put(field_char($urandom_range(0, 99) < 85));
    if (cut == 2) return;
    put(CH_COMMA);
    n = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 8) : $urandom_range(9, 12);
    repeat (n) put(field_char($urandom_range(0, 99) < 90));
    if (cut == 3) return;
    put(CH_COMMA);
    r = $urandom_range(0, 99);
    if (r < 80) put(CH_STAR);
    else if (r >= 90) repeat ($urandom_range(1, 3)) put(field_char(1'b0));
    if (cut == 4) return;
    put(CH_COMMA);
    if (cut == 5) begin
      put_raw(hex_char($urandom_range(0, 15)));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 62) begin
      close_good();
    end else if (r < 70) begin
      bad = gen_xor ^ 8'($urandom_range(1, 255));
      put_raw(hex_char(bad[7:4]));
      put_raw(hex_char(bad[3:0]));
    end else if (r < 76) begin
      n = $urandom_range(0, 5);
      put_raw((n == 5) ? CH_SPACE : CH_TAB + 8'(n));
      put_raw(hex_char($urandom_range(0, 15)));
    end else if (r < 84) begin
      put_raw($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
      put_raw(hex_char(gen_xor[3:0]));
    end else if (r < 90) begin
      put_raw(hex_char(gen_xor[7:4]));
      put_raw(non_hex_char());
    end else if (r < 95) begin
      put_raw(non_hex_char());
      put_raw(field_char(1'b0));
    end else begin
      put_raw(8'($urandom_range(0, 255)));
      put_raw(8'($urandom_range(0, 255)));
    end
  endfunction

  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void note_fail(string what, result_t want, result_t got);
    fail_cnt++;
    if (fail_cnt <= 10)
      $display("%s: expected code=%0d msg=%0d param=%0d sum=%02h ok=%0b, ",
               what, want.sensor_code, want.message_number, want.param_value,
               want.received_sum, want.sum_matches,
               "got code=%0d msg=%0d param=%0d sum=%02h ok=%0b",
               got.sensor_code, got.message_number, got.param_value,
               got.received_sum, got.sum_matches);
  endfunction

  // ---- clock, reset, stimulus and end of run ----

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stim
    int r;
    rst            = 1'b1;
    rx_if.valid    = 1'b0;
    rx_if.rx_byte  = '0;
    res_if.ready   = 1'b0;

    // Bytes outside a frame are ignored
    put_raw(8'h00);
    put_raw(8'hFF);
    put_raw("A");
    // Largest well-formed fields
    open_frame(); put_text("CNTRL,99,99999999,*,"); close_good();
    // Extra ID characters, too many digits, doubled star
    open_frame(); put_text("PRS01xy,123,123456789012,**,"); close_good();
    // Non-digit bytes in both numeric fields, empty star field
    open_frame(); put_text("HZ21W,A~,");
    repeat (8) put(8'hFF);
    put_text(",,"); close_good();
    // Leading white space, plus sign, short ID
    open_frame(); put_text("DS18B,,,,"); put_raw(CH_SPACE); put_raw("5");
    open_frame(); put_text("CN,1,2,*,"); put_raw(CH_PLUS); put_raw("A");
    // Unknown ID: the rest of the frame is dropped
    open_frame(); put_text("NOPE1,3,4,*,"); put_raw("1"); put_raw("2");
    // Minus sign, non-hex first, non-hex second, no digits at all
    open_frame(); put_text("DS18B,5,5,*,"); put_raw(CH_MINUS); put_raw("3");
    open_frame(); put_text("CNTRL,1,2,*,"); put_raw("G"); put_raw("1");
    open_frame(); put_text("ACST1,1,2,*,"); put_raw("a"); put_raw("?");
    open_frame(); put_text("PRS01,1,2,*,"); put_raw(CH_MINUS); put_raw(CH_MINUS);
    // Restart in the middle of the checksum
    open_frame(); put_text("HZ21W,7,8,*,"); put_raw("4");
    open_frame(); put_text("ACST1,3,4,*,"); close_good();
    // Zero fields
    open_frame(); put_text("CNTRL,00,00000000,*,"); close_good();

    while (frame_bytes < STREAM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 8)
        repeat ($urandom_range(1, 4)) put_raw(8'($urandom_range(0, 255)));
      else if (r < 16)
        gen_frame($urandom_range(1, 5));
      else
        gen_frame(6);
    end
    byte_total = byte_q.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (bytes_taken != byte_total || frame_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (frame_q.size() != 0) begin
      fail_cnt += frame_q.size();
      $display("%0d expected results never arrived", frame_q.size());
    end
    if (fail_cnt == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  // ---- byte driver ----

  always @(posedge clk) begin : drive
    if (rst) begin
      rx_if.valid <= 1'b0;
    end else if (!rx_if.valid || rx_if.ready) begin
      if (send_gap > 0) begin
        send_gap--;
        rx_if.valid <= 1'b0;
      end else if (byte_q.size() > 0) begin
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= byte_q.pop_front();
        if ($urandom_range(0, 199) == 0) send_calm = !send_calm;
        send_gap = send_calm ? 0 : pick_pause();
      end else begin
        rx_if.valid <= 1'b0;
      end
    end
  end

  // ---- result ready pacing ----

  always @(posedge clk) begin : pace
    if (rst) begin
      res_if.ready <= 1'b0;
    end else if (take_stall > 0) begin
      take_stall--;
      res_if.ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) take_calm = !take_calm;
      take_stall = take_calm ? 0 : pick_pause();
      res_if.ready <= (take_stall == 0);
      if (take_stall > 0) take_stall--;
    end
  end

  // ---- monitor: decode accepted bytes, then check result beats ----

  always @(posedge clk) begin : watch
    result_t want;
    result_t got;
    if (!rst) begin
      if (rx_if.valid && rx_if.ready) begin
        bytes_taken++;
        if (take_byte(rx_if.rx_byte, want)) frame_q.push_back(want);
      end
      if (res_if.valid && res_if.ready) begin
        got.sensor_code    = res_if.sensor_code;
        got.message_number = res_if.message_number;
        got.param_value    = res_if.param_value;
        got.received_sum   = res_if.received_sum;
        got.sum_matches    = res_if.sum_matches;
        if (frame_q.size() == 0) begin
          note_fail("unexpected result", '0, got);
        end else begin
          want = frame_q.pop_front();
          if (got.sensor_code !== want.sensor_code ||
              got.message_number !== want.message_number ||
              got.param_value !== want.param_value ||
              got.received_sum !== want.received_sum ||
              got.sum_matches !== want.sum_matches)
            note_fail("result mismatch", want, got);
        end
      end
    end
  end

endmodule
